// ----- hdl/cubic_spline_tessellator_top_macros.svh -----
// Assertion macros for the cubic spline tessellator.
// Used by the top level; no other dependencies.
`ifndef CUBIC_SPLINE_TESSELLATOR_TOP_MACROS_SVH
`define CUBIC_SPLINE_TESSELLATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define CSP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define CSP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CSP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define CSP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hdl/csp_pkg.sv -----
// Shared types, constants and arithmetic helpers of the cubic spline tessellator.
// No dependencies; imported by every module of the block.
`default_nettype none
package csp_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int COORD_WIDTH = 32;
   localparam int T_BITS      = 16;
   localparam int CSR_WIDTH   = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int PROD_WIDTH  = 2 * (COORD_WIDTH + 1);

   localparam logic [T_BITS-1:0] MIN_STEP = T_BITS'(2048);

   // Configuration register indexes.
   localparam logic [1:0] CSR_SPLINE_MODE  = 2'd0;
   localparam logic [1:0] CSR_CLOSED_CURVE = 2'd1;
   localparam logic [1:0] CSR_T_STEP       = 2'd2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [2:0][COORD_WIDTH-1:0]   vec3_type;

   // One segment handed from the front end to the sample engine.
   typedef struct packed {
      vec3_type pa;
      vec3_type ra;
      vec3_type pb;
      vec3_type rb;
      logic     last;
   } seg_type;

   typedef enum logic [2:0] {
      F_IDLE, F_CALC, F_PUSH_A, F_PUSH_B, F_SHIFT
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE, B_SQUARE, B_CUBE, B_BASIS, B_MAC, B_EMIT
   } back_state_type;

   // Saturate a one-bit-wider signed value to the coordinate range.
   function automatic coord_type sat_wide1(input logic signed [COORD_WIDTH:0] x);
      coord_type r;
      if (x[COORD_WIDTH] != x[COORD_WIDTH-1]) begin
         r = x[COORD_WIDTH] ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else begin
         r = x[COORD_WIDTH-1:0];
      end
      return r;
   endfunction

   // Round a product by 2^FRAC_BITS (or 2^(FRAC_BITS+1)) half away from zero, saturate.
   function automatic coord_type mulq_round(input logic signed [PROD_WIDTH-1:0] prod,
                                            input logic extra);
      logic                   neg;
      logic [PROD_WIDTH-1:0]  mag;
      logic [PROD_WIDTH-1:0]  rnd;
      logic [PROD_WIDTH-1:0]  sh;
      logic [PROD_WIDTH-1:0]  lim;
      logic [COORD_WIDTH-1:0] m;
      neg = prod[PROD_WIDTH-1];
      mag = neg ? PROD_WIDTH'(-prod) : prod;
      if (extra) begin
         rnd = mag + (PROD_WIDTH'(1) << FRAC_BITS);
         sh  = rnd >> (FRAC_BITS + 1);
      end else begin
         rnd = mag + (PROD_WIDTH'(1) << (FRAC_BITS - 1));
         sh  = rnd >> FRAC_BITS;
      end
      lim = neg ? (PROD_WIDTH'(1) << (COORD_WIDTH - 1))
                : ((PROD_WIDTH'(1) << (COORD_WIDTH - 1)) - PROD_WIDTH'(1));
      m   = (sh > lim) ? lim[COORD_WIDTH-1:0] : sh[COORD_WIDTH-1:0];
      return neg ? coord_type'(-m) : coord_type'(m);
   endfunction

endpackage
`default_nettype wire

// ----- hdl/csp_queue.sv -----
// Short segment queue between the front end and the sample engine.
// Depends on csp_pkg.
`default_nettype none
module csp_queue
   import csp_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     push,
   input  seg_type push_data,
   output logic    full,
   input  wire     pop,
   output seg_type pop_data,
   output logic    empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   seg_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/csp_front.sv -----
// Front end: accepts control points, keeps the window, derives KB tangents.
// Depends on csp_pkg; feeds csp_queue.
`default_nettype none
module csp_front
   import csp_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  wire      req_tvalid,
   output logic     req_tready,
   input  vec3_type req_point,
   input  vec3_type req_aux,
   input  wire      req_eoc,
   input  wire      spline_mode,
   input  wire      closed_curve,
   output logic     q_push,
   output seg_type  q_data,
   input  wire      q_full
);

   localparam logic [4:0] OP_AB   = 5'd0;
   localparam logic [4:0] OP_AM   = 5'd1;
   localparam logic [4:0] OP_C1   = 5'd2;
   localparam logic [4:0] OP_C2   = 5'd3;
   localparam logic [4:0] OP_C3   = 5'd4;
   localparam logic [4:0] OP_C4   = 5'd5;
   localparam logic [4:0] OP_AXIS = 5'd6;
   localparam logic [4:0] OP_LAST = 5'd17;
   localparam logic [1:0] SUB_R1A = 2'd0;
   localparam logic [1:0] SUB_R1B = 2'd1;
   localparam logic [1:0] SUB_R2A = 2'd2;
   localparam logic [1:0] SUB_R2B = 2'd3;

   localparam logic signed [COORD_WIDTH:0] ONE = (COORD_WIDTH+1)'(1) << FRAC_BITS;

   front_state_type state_ff, state_in;

   vec3_type   win_p_ff [3];
   vec3_type   win_a_ff [3];
   vec3_type   first_p_ff, first_a_ff;
   vec3_type   in_p_ff, in_a_ff;
   logic       in_eoc_ff;
   logic       close_ff;
   logic [1:0] seen_ff;

   logic [4:0] op_ff;
   logic       phase_ff;
   logic signed [PROD_WIDTH-1:0] prod_ff;
   coord_type  ab_ff, am_ff, c1_ff, c2_ff, c3_ff, c4_ff, tmp_ff;
   vec3_type   r1_ff, r2_ff;

   logic       accept;
   logic [4:0] rel;
   logic [1:0] ax, sub;
   coord_type  om, bp, bm, cp, cm;
   logic signed [COORD_WIDTH:0] d21, d32, d43;
   logic signed [COORD_WIDTH:0] opa, opb;
   logic       extra;
   coord_type  res;
   coord_type  acc_sum;

   assign accept = req_tvalid && req_tready;
   assign rel    = op_ff - OP_AXIS;
   assign ax     = rel[3:2];
   assign sub    = rel[1:0];

   // Tension, bias and continuity come from the oldest window point.
   assign om = sat_wide1(ONE - $signed({win_a_ff[0][0][COORD_WIDTH-1], win_a_ff[0][0]}));
   assign bp = sat_wide1(ONE + $signed({win_a_ff[0][1][COORD_WIDTH-1], win_a_ff[0][1]}));
   assign bm = sat_wide1(ONE - $signed({win_a_ff[0][1][COORD_WIDTH-1], win_a_ff[0][1]}));
   assign cp = sat_wide1(ONE + $signed({win_a_ff[0][2][COORD_WIDTH-1], win_a_ff[0][2]}));
   assign cm = sat_wide1(ONE - $signed({win_a_ff[0][2][COORD_WIDTH-1], win_a_ff[0][2]}));

   assign d21 = $signed({win_p_ff[1][ax][COORD_WIDTH-1], win_p_ff[1][ax]})
              - $signed({win_p_ff[0][ax][COORD_WIDTH-1], win_p_ff[0][ax]});
   assign d32 = $signed({win_p_ff[2][ax][COORD_WIDTH-1], win_p_ff[2][ax]})
              - $signed({win_p_ff[1][ax][COORD_WIDTH-1], win_p_ff[1][ax]});
   assign d43 = $signed({in_p_ff[ax][COORD_WIDTH-1], in_p_ff[ax]})
              - $signed({win_p_ff[2][ax][COORD_WIDTH-1], win_p_ff[2][ax]});

   always_comb begin
      opa   = '0;
      opb   = '0;
      extra = 1'b0;
      unique case (op_ff)
         OP_AB: begin opa = {om[COORD_WIDTH-1], om}; opb = {bp[COORD_WIDTH-1], bp}; end
         OP_AM: begin opa = {om[COORD_WIDTH-1], om}; opb = {bm[COORD_WIDTH-1], bm}; end
         OP_C1: begin
            opa = {ab_ff[COORD_WIDTH-1], ab_ff}; opb = {cp[COORD_WIDTH-1], cp}; extra = 1'b1;
         end
         OP_C2: begin
            opa = {am_ff[COORD_WIDTH-1], am_ff}; opb = {cm[COORD_WIDTH-1], cm}; extra = 1'b1;
         end
         OP_C3: begin
            opa = {ab_ff[COORD_WIDTH-1], ab_ff}; opb = {cm[COORD_WIDTH-1], cm}; extra = 1'b1;
         end
         OP_C4: begin
            opa = {am_ff[COORD_WIDTH-1], am_ff}; opb = {cp[COORD_WIDTH-1], cp}; extra = 1'b1;
         end
         default: begin
            unique case (sub)
               SUB_R1A: begin opa = {c1_ff[COORD_WIDTH-1], c1_ff}; opb = d21; end
               SUB_R1B: begin opa = {c2_ff[COORD_WIDTH-1], c2_ff}; opb = d32; end
               SUB_R2A: begin opa = {c3_ff[COORD_WIDTH-1], c3_ff}; opb = d32; end
               SUB_R2B: begin opa = {c4_ff[COORD_WIDTH-1], c4_ff}; opb = d43; end
               default: begin opa = '0; opb = '0; end
            endcase
         end
      endcase
   end

   assign res     = mulq_round(prod_ff, extra);
   assign acc_sum = sat_wide1($signed({tmp_ff[COORD_WIDTH-1], tmp_ff})
                              + $signed({res[COORD_WIDTH-1], res}));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               if (!spline_mode) begin
                  state_in = (seen_ff != 2'd0) ? F_PUSH_A : F_SHIFT;
               end else begin
                  state_in = (seen_ff == 2'd3) ? F_CALC : F_SHIFT;
               end
            end
         end
         F_CALC:   if (phase_ff && op_ff == OP_LAST) state_in = F_PUSH_A;
         F_PUSH_A: if (!q_full) state_in = close_ff ? F_PUSH_B : F_SHIFT;
         F_PUSH_B: if (!q_full) state_in = F_SHIFT;
         F_SHIFT:  state_in = F_IDLE;
         default:  state_in = F_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_tready = 1'b0;
      q_push     = 1'b0;
      q_data     = '0;
      unique case (state_ff)
         F_IDLE: req_tready = 1'b1;
         F_PUSH_A: begin
            q_push    = !q_full;
            q_data.pb = in_p_ff;
            if (spline_mode) begin
               q_data.pa = win_p_ff[1];
               q_data.ra = r1_ff;
               q_data.pb = win_p_ff[2];
               q_data.rb = r2_ff;
            end else begin
               q_data.pa = win_p_ff[2];
               q_data.ra = win_a_ff[2];
               q_data.rb = in_a_ff;
            end
            q_data.last = !close_ff;
         end
         F_PUSH_B: begin
            q_push      = !q_full;
            q_data.pa   = first_p_ff;
            q_data.ra   = first_a_ff;
            q_data.pb   = in_p_ff;
            q_data.rb   = in_a_ff;
            q_data.last = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         seen_ff  <= '0;
         op_ff    <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            op_ff    <= '0;
            phase_ff <= 1'b0;
         end else if (state_ff == F_CALC) begin
            phase_ff <= !phase_ff;
            if (phase_ff) op_ff <= op_ff + 5'd1;
         end
         if (state_ff == F_SHIFT) begin
            if (in_eoc_ff) begin
               seen_ff <= '0;
            end else if (seen_ff != 2'd3) begin
               seen_ff <= seen_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_p_ff   <= req_point;
         in_a_ff   <= req_aux;
         in_eoc_ff <= req_eoc;
         close_ff  <= !spline_mode && closed_curve && req_eoc && (seen_ff != 2'd0);
         if (seen_ff == 2'd0) begin
            first_p_ff <= req_point;
            first_a_ff <= req_aux;
         end
      end
      if (state_ff == F_CALC) begin
         if (!phase_ff) begin
            prod_ff <= opa * opb;
         end else begin
            unique case (op_ff)
               OP_AB: ab_ff <= res;
               OP_AM: am_ff <= res;
               OP_C1: c1_ff <= res;
               OP_C2: c2_ff <= res;
               OP_C3: c3_ff <= res;
               OP_C4: c4_ff <= res;
               default: begin
                  unique case (sub)
                     SUB_R1A: tmp_ff <= res;
                     SUB_R1B: r1_ff[ax] <= acc_sum;
                     SUB_R2A: tmp_ff <= res;
                     SUB_R2B: r2_ff[ax] <= acc_sum;
                     default: ;
                  endcase
               end
            endcase
         end
      end
      if (state_ff == F_SHIFT) begin
         win_p_ff[0] <= win_p_ff[1];
         win_p_ff[1] <= win_p_ff[2];
         win_p_ff[2] <= in_p_ff;
         win_a_ff[0] <= win_a_ff[1];
         win_a_ff[1] <= win_a_ff[2];
         win_a_ff[2] <= in_a_ff;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/csp_back.sv -----
// Sample engine: steps t over one segment and evaluates the Hermite sum per axis.
// Depends on csp_pkg; drains csp_queue, owns the result register.
`default_nettype none
module csp_back
   import csp_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire [T_BITS-1:0]  t_step,
   input  seg_type           q_data,
   input  wire               q_empty,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output vec3_type          rsp_point,
   output logic              rsp_last
);

   localparam int BIG_W = 3 * T_BITS + 5;
   localparam int H_W   = T_BITS + 2;
   localparam int ACC_W = COORD_WIDTH + H_W + 4;

   back_state_type state_ff, state_in;

   seg_type            seg_ff;
   logic [T_BITS-1:0]  t_ff;
   logic [2*T_BITS-1:0] tsq_ff;
   logic [3*T_BITS-1:0] t3_ff;
   logic signed [H_W-1:0] h_ff [4];
   logic [1:0]         k_ff;
   logic signed [ACC_W-1:0] acc_ff [3];
   logic               valid_ff;
   vec3_type           point_ff;
   logic               last_ff;

   logic [T_BITS-1:0]  step;
   logic [T_BITS:0]    t_next;
   logic               slot_free;
   logic signed [BIG_W-1:0] t2s, t3s, tls, one_s;
   logic signed [BIG_W-1:0] big [4];
   vec3_type           vsel;
   vec3_type           sample;

   assign step      = (t_step < MIN_STEP) ? MIN_STEP : t_step;
   assign t_next    = {1'b0, t_ff} + {1'b0, step};
   assign slot_free = !valid_ff || rsp_tready;

   assign t2s   = $signed({5'd0, tsq_ff, {T_BITS{1'b0}}});
   assign t3s   = $signed({5'd0, t3_ff});
   assign tls   = $signed({5'd0, t_ff, {(2*T_BITS){1'b0}}});
   assign one_s = BIG_W'(1) <<< (3 * T_BITS);
   assign big[0] = 2 * t3s - 3 * t2s + one_s;
   assign big[1] = 3 * t2s - 2 * t3s;
   assign big[2] = t3s - 2 * t2s + tls;
   assign big[3] = t3s - t2s;

   always_comb begin
      unique case (k_ff)
         2'd0:    vsel = seg_ff.pa;
         2'd1:    vsel = seg_ff.pb;
         2'd2:    vsel = seg_ff.ra;
         default: vsel = seg_ff.rb;
      endcase
   end

   // Round each axis sum to FRAC_BITS and clamp to the coordinate range.
   always_comb begin
      logic signed [ACC_W-1:0] r;
      for (int a = 0; a < 3; a++) begin
         r = (acc_ff[a] + (ACC_W'(1) <<< (T_BITS - 1))) >>> T_BITS;
         if (r > $signed(ACC_W'({1'b0, {(COORD_WIDTH-1){1'b1}}}))) begin
            sample[a] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
         end else if (r < -(ACC_W'(1) <<< (COORD_WIDTH - 1))) begin
            sample[a] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
         end else begin
            sample[a] = r[COORD_WIDTH-1:0];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:   if (!q_empty) state_in = B_SQUARE;
         B_SQUARE: state_in = B_CUBE;
         B_CUBE:   state_in = B_BASIS;
         B_BASIS:  state_in = B_MAC;
         B_MAC:    if (k_ff == 2'd3) state_in = B_EMIT;
         B_EMIT:   if (slot_free) state_in = t_next[T_BITS] ? B_IDLE : B_SQUARE;
         default:  state_in = B_IDLE;
      endcase
   end

   always_comb begin
      q_pop = (state_ff == B_IDLE) && !q_empty;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_point  = point_ff;
   assign rsp_last   = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_EMIT && slot_free) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            seg_ff <= q_data;
            t_ff   <= '0;
         end
         B_SQUARE: tsq_ff <= t_ff * t_ff;
         B_CUBE:   t3_ff  <= tsq_ff * t_ff;
         B_BASIS: begin
            for (int k = 0; k < 4; k++) begin
               h_ff[k] <= H_W'((big[k] + (BIG_W'(1) <<< (2*T_BITS - 1))) >>> (2*T_BITS));
            end
            for (int a = 0; a < 3; a++) acc_ff[a] <= '0;
            k_ff <= '0;
         end
         B_MAC: begin
            for (int a = 0; a < 3; a++) begin
               acc_ff[a] <= acc_ff[a] + ACC_W'($signed(vsel[a]) * h_ff[k_ff]);
            end
            k_ff <= k_ff + 2'd1;
         end
         B_EMIT: begin
            if (slot_free) begin
               point_ff <= sample;
               last_ff  <= seg_ff.last && t_next[T_BITS];
               t_ff     <= t_next[T_BITS-1:0];
            end
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// ----- hdl/cubic_spline_tessellator_top.sv -----
// Top level of the cubic spline tessellator: configuration registers and wiring.
// Depends on csp_pkg, csp_front, csp_queue, csp_back and the assertion macro header.
//
//  Channel  Direction  Transaction carries
//  req_*    in         one control point: position, three aux values, end of curve (tlast)
//  rsp_*    out        one curve sample: x, y, z, last sample of this point (tlast)
//  csr_*    in         one register write: index and data
//
// The front end takes a point, pushes each segment in a state of its own and then shifts
// the window; a Kochanek-Bartels point adds tangent math through one shared multiplier.
// Each sample passes the engine's steps (square, cube, basis, four multiply-accumulate
// steps on three axis lanes, emit); each segment is first fetched from the queue.
// A two-entry segment queue lets the front end take the next point while samples still
// drain. Reset is synchronous and clears all control state; a stalled result holds in the
// output register and back-pressures the sample engine, and once the queue fills, the
// front end as well.
`default_nettype none
`include "cubic_spline_tessellator_top_macros.svh"
module cubic_spline_tessellator_top
   import csp_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire [6*COORD_WIDTH-1:0] req_tdata,  // pos_x, pos_y, pos_z, aux_a, aux_b, aux_c
   input  wire                  req_tlast,     // end_of_curve
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [3*COORD_WIDTH-1:0] rsp_tdata, // out_x, out_y, out_z
   output logic                 rsp_tlast,     // last_of_run
   input  wire                  csr_we,
   input  wire [1:0]            csr_index,
   input  wire [CSR_WIDTH-1:0]  csr_wdata
);

   // Configuration registers; the user must write them only while the block is idle (not enforced here).
   logic              mode_ff;
   logic              closed_ff;
   logic [T_BITS-1:0] t_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         closed_ff <= 1'b0;
         t_step_ff <= T_BITS'(3277);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPLINE_MODE:  mode_ff   <= csr_wdata[0];
            CSR_CLOSED_CURVE: closed_ff <= csr_wdata[0];
            CSR_T_STEP:       t_step_ff <= csr_wdata[T_BITS-1:0];
            default: ;
         endcase
      end
   end

   seg_type  q_push_data, q_pop_data;
   logic     q_push, q_pop, q_full, q_empty;
   vec3_type rsp_point;

   csp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_point    (vec3_type'(req_tdata[3*COORD_WIDTH-1:0])),
      .req_aux      (vec3_type'(req_tdata[6*COORD_WIDTH-1:3*COORD_WIDTH])),
      .req_eoc      (req_tlast),
      .spline_mode  (mode_ff),
      .closed_curve (closed_ff),
      .q_push       (q_push),
      .q_data       (q_push_data),
      .q_full       (q_full)
   );

   csp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   csp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .t_step     (t_step_ff),
      .q_data     (q_pop_data),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_point  (rsp_point),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = rsp_point;

   // The front end never pushes into a full queue, the engine never pops an empty one,
   // and a push into a half-full two-entry queue without a pop fills it.
   `CSP_ASSERT_IMPL(a_no_push_full, clock, reset, q_push, !q_full, "push into full queue")
   `CSP_ASSERT_IMPL(a_no_pop_empty, clock, reset, q_pop, !q_empty, "pop from empty queue")
   `CSP_ASSERT_NEXT(a_fill, clock, reset, q_push && !q_pop && !q_empty && !q_full, q_full, "queue did not fill")

endmodule
`default_nettype wire

// ----- sim/csp_sample_checker.sv -----
`timescale 1ns / 100ps
// Checker for the cubic spline tessellator: it predicts the curve samples and compares them.
// Depends on csp_pkg; it is instantiated beside the block by tb_cubic_spline_tessellator_top.
module csp_sample_checker
   import csp_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   input  wire                      req_tready,
   input  wire [6*COORD_WIDTH-1:0]  req_tdata,
   input  wire                      req_tlast,
   input  wire                      rsp_tvalid,
   input  wire                      rsp_tready,
   input  wire [3*COORD_WIDTH-1:0]  rsp_tdata,
   input  wire                      rsp_tlast,
   input  wire                      csr_we,
   input  wire [1:0]                csr_index,
   input  wire [CSR_WIDTH-1:0]      csr_wdata,
   output int                       fail_count,
   output int                       pending,
   output int                       sample_count
);

   typedef struct {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      last;
   } sample_type;

   localparam longint ONE = longint'(1) << FRAC_BITS;
   localparam longint HI  = (longint'(1) << (COORD_WIDTH - 1)) - 1;
   localparam longint LO  = -HI - 1;

   sample_type      sample_q[$];
   longint          win_p[9];
   longint          win_a[9];
   longint          first_p[3];
   longint          first_a[3];
   int              seen;
   logic            kb_mode;
   logic            closed;
   logic [15:0]     step_reg;

   function automatic longint clip(input longint v);
      return v > HI ? HI : (v < LO ? LO : v);
   endfunction

   function automatic longint fx_mul(input longint a, input longint b, input int s);
      logic signed [127:0] p;
      logic [127:0]        mag;
      logic [127:0]        lim;
      logic                neg;
      neg = (a < 0) != (b < 0);
      p   = 128'(a) * 128'(b);
      mag = p[127] ? -p : p;
      mag = (mag + (128'(1) << (s - 1))) >> s;
      lim = neg ? 128'(HI) + 1 : 128'(HI);
      if (mag > lim) mag = lim;
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   // Appends the samples of one segment from point a to point b.
   function automatic void push_segment(input longint pa[3], input longint ra[3],
                                        input longint pb[3], input longint rb[3]);
      longint     t, t2, t3, acc;
      longint     h[4];
      longint     v[4];
      longint     big[4];
      int unsigned inc;
      sample_type s;
      longint     r[3];
      inc = (step_reg < MIN_STEP) ? MIN_STEP : step_reg;
      for (t = 0; t < 65536; t += inc) begin
         t2 = t * t * 65536;
         t3 = t * t * t;
         big[0] = 2 * t3 - 3 * t2 + (longint'(1) << 48);
         big[1] = -2 * t3 + 3 * t2;
         big[2] = t3 - 2 * t2 + t * (longint'(1) << 32);
         big[3] = t3 - t2;
         for (int k = 0; k < 4; k++) h[k] = (big[k] + (longint'(1) << 31)) >>> 32;
         for (int ax = 0; ax < 3; ax++) begin
            v[0] = pa[ax]; v[1] = pb[ax]; v[2] = ra[ax]; v[3] = rb[ax];
            acc = 0;
            for (int k = 0; k < 4; k++) acc += v[k] * h[k];
            r[ax] = clip((acc + 32768) >>> 16);
         end
         s.x = coord_type'(r[0]);
         s.y = coord_type'(r[1]);
         s.z = coord_type'(r[2]);
         s.last = 1'b0;
         sample_q.insert(sample_q.size(), s);
      end
   endfunction

   // Updates the window with one accepted control point and predicts its samples.
   function automatic void take_point(input logic [6*COORD_WIDTH-1:0] d, input logic eoc);
      longint p[3], a[3], pa[3], ra[3], pb[3], rb[3];
      longint om, bp, bm, cp, cm, ab, am, c1, c2, c3, c4, d21, d32, d43;
      int     n_prior;
      n_prior = sample_q.size();
      for (int ax = 0; ax < 3; ax++) begin
         p[ax] = longint'(coord_type'(d[ax*COORD_WIDTH +: COORD_WIDTH]));
         a[ax] = longint'(coord_type'(d[(ax+3)*COORD_WIDTH +: COORD_WIDTH]));
      end
      if (seen == 0) begin
         first_p = p;
         first_a = a;
      end
      if (!kb_mode) begin
         if (seen >= 1) begin
            for (int ax = 0; ax < 3; ax++) begin
               pa[ax] = win_p[6+ax];
               ra[ax] = win_a[6+ax];
            end
            push_segment(pa, ra, p, a);
            // Closing segment runs from the first point of the curve to this one.
            if (eoc && closed) push_segment(first_p, first_a, p, a);
         end
      end else if (seen == 3) begin
         om = clip(ONE - win_a[0]);
         bp = clip(ONE + win_a[1]);
         bm = clip(ONE - win_a[1]);
         cp = clip(ONE + win_a[2]);
         cm = clip(ONE - win_a[2]);
         ab = fx_mul(om, bp, FRAC_BITS);
         am = fx_mul(om, bm, FRAC_BITS);
         c1 = fx_mul(ab, cp, FRAC_BITS + 1);
         c2 = fx_mul(am, cm, FRAC_BITS + 1);
         c3 = fx_mul(ab, cm, FRAC_BITS + 1);
         c4 = fx_mul(am, cp, FRAC_BITS + 1);
         for (int ax = 0; ax < 3; ax++) begin
            d21 = win_p[3+ax] - win_p[ax];
            d32 = win_p[6+ax] - win_p[3+ax];
            d43 = p[ax] - win_p[6+ax];
            ra[ax] = clip(fx_mul(c1, d21, FRAC_BITS) + fx_mul(c2, d32, FRAC_BITS));
            rb[ax] = clip(fx_mul(c3, d32, FRAC_BITS) + fx_mul(c4, d43, FRAC_BITS));
            pa[ax] = win_p[3+ax];
            pb[ax] = win_p[6+ax];
         end
         push_segment(pa, ra, pb, rb);
      end
      for (int i = 0; i < 6; i++) begin
         win_p[i] = win_p[i+3];
         win_a[i] = win_a[i+3];
      end
      for (int ax = 0; ax < 3; ax++) begin
         win_p[6+ax] = p[ax];
         win_a[6+ax] = a[ax];
      end
      if (seen < 3) seen++;
      if (eoc) begin
         for (int i = 0; i < 9; i++) begin
            win_p[i] = 0;
            win_a[i] = 0;
         end
         seen = 0;
      end
      if (sample_q.size() > n_prior) sample_q[$].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      sample_type exp_s;
      coord_type  got_x, got_y, got_z;
      if (reset) begin
         sample_q.delete();
         for (int i = 0; i < 9; i++) begin
            win_p[i] = 0;
            win_a[i] = 0;
         end
         for (int i = 0; i < 3; i++) begin
            first_p[i] = 0;
            first_a[i] = 0;
         end
         seen = 0;
         kb_mode = 1'b0;
         closed = 1'b0;
         step_reg = 16'd3277;
         fail_count = 0;
         sample_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sample_count++;
            got_x = rsp_tdata[0 +: COORD_WIDTH];
            got_y = rsp_tdata[COORD_WIDTH +: COORD_WIDTH];
            got_z = rsp_tdata[2*COORD_WIDTH +: COORD_WIDTH];
            if (sample_q.size() == 0) begin
               $error("unexpected sample x=%h y=%h z=%h", got_x, got_y, got_z);
               fail_count++;
            end else begin
               exp_s = sample_q.pop_front();
               if (got_x !== exp_s.x) begin
                  $error("out_x expected %h actual %h", exp_s.x, got_x);
                  fail_count++;
               end
               if (got_y !== exp_s.y) begin
                  $error("out_y expected %h actual %h", exp_s.y, got_y);
                  fail_count++;
               end
               if (got_z !== exp_s.z) begin
                  $error("out_z expected %h actual %h", exp_s.z, got_z);
                  fail_count++;
               end
               if (rsp_tlast !== exp_s.last) begin
                  $error("last_of_run expected %b actual %b", exp_s.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) take_point(req_tdata, req_tlast);
         if (csr_we) begin
            case (csr_index)
               CSR_SPLINE_MODE:  kb_mode  = csr_wdata[0];
               CSR_CLOSED_CURVE: closed   = csr_wdata[0];
               CSR_T_STEP:       step_reg = csr_wdata[15:0];
               default: ;
            endcase
         end
      end
      pending = sample_q.size();
   end

endmodule

// ----- sim/tb_cubic_spline_tessellator_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the cubic spline tessellator: clock, reset, stimulus and verdict.
// Depends on csp_pkg, the block and csp_sample_checker, which does all result checking.
module tb_cubic_spline_tessellator_top;
   import csp_pkg::*;

   // Cycles without any transaction before the run is declared hung. This leaves a wide margin
   // over the sample work of a point plus receiver stalls, and over the quiet SETTLE waits
   // before register writes.
   localparam int HANG_LIMIT = 5000;
   localparam int SETTLE     = 200;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   wire                      req_tready;
   logic [6*COORD_WIDTH-1:0] req_tdata;
   logic                     req_tlast;
   wire                      rsp_tvalid;
   logic                     rsp_tready;
   wire  [3*COORD_WIDTH-1:0] rsp_tdata;
   wire                      rsp_tlast;
   logic                     csr_we;
   logic [1:0]               csr_index;
   logic [CSR_WIDTH-1:0]     csr_wdata;
   int                       fail_count;
   int                       pending;
   int                       sample_count;
   int                       point_count;
   int                       quiet_cycles;
   logic                     no_idle;

   cubic_spline_tessellator_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   csp_sample_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending), .sample_count(sample_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The result side stalls in random bursts until the final phase, then stays ready.
   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(posedge clock);
         if (!no_idle && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Any transaction on either channel restarts the hang counter.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("Timeout after %0d quiet cycles", quiet_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Waits until every predicted sample has arrived, then lets the front end settle, since
   // a point that yields no samples may still be working on the window.
   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_WIDTH'(val);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic configure(input bit kb, input bit cl, input int unsigned stp);
      drain();
      write_reg(CSR_SPLINE_MODE, kb);
      write_reg(CSR_CLOSED_CURVE, cl);
      write_reg(CSR_T_STEP, stp);
   endtask

   // Presents one control point and holds it until the transaction completes. Valid drops
   // right after it, so a point is never offered twice; a gap may follow.
   task automatic send_point(input coord_type px, py, pz, ax, ay, az, input logic eoc);
      @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {az, ay, ax, pz, py, px};
      req_tlast  <= eoc;
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
      point_count++;
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   function automatic coord_type rand_pos();
      case ($urandom_range(0, 9))
         0: return coord_type'($urandom);
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return coord_type'($signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000);
      endcase
   endfunction

   // Tangents in Hermite mode, or tension, bias and continuity near the unit range.
   function automatic coord_type rand_aux(input bit kb);
      case ($urandom_range(0, 9))
         0: return coord_type'($urandom);
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default:
            if (kb) return coord_type'($signed($urandom_range(0, 32'h00040000)) - 32'sh00020000);
            else return rand_pos();
      endcase
   endfunction

   // Mostly whole curves of random length; a few stray single points as noise.
   task automatic random_curves(input int n, input bit kb);
      int len;
      while (n > 0) begin
         len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 6);
         for (int i = 0; i < len && n > 0; i++) begin
            send_point(rand_pos(), rand_pos(), rand_pos(), rand_aux(kb), rand_aux(kb),
                       rand_aux(kb), (i == len - 1) || (n == 1));
            n--;
         end
      end
   endtask

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = CSR_SPLINE_MODE;
      csr_wdata  = '0;
      no_idle    = 1'b0;
      point_count = 0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first with the reset settings: a one-point curve gives nothing,
      // then a Hermite curve through the coordinate extremes.
      send_point(32'sh00010000, 0, 0, 0, 0, 0, 1'b1);
      send_point(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 32'h80000000, 0, 1'b0);
      send_point(32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h80000000, 32'h7fffffff,
                 32'hffffffff, 1'b0);
      send_point(0, 0, 0, 0, 0, 0, 1'b1);

      // Closed Hermite curve at the smallest legal step; a one-point closed curve
      // has no closing segment.
      configure(1'b0, 1'b1, MIN_STEP);
      send_point(32'sh00050000, 32'sh00020000, -32'sh00010000, 32'sh00010000, 0, 0, 1'b1);
      send_point(0, 0, 0, 32'sh00030000, 32'sh00030000, 32'sh00030000, 1'b0);
      send_point(32'sh00100000, -32'sh00100000, 32'sh00080000, -32'sh00020000, 0,
                 32'sh00010000, 1'b0);
      send_point(32'h7fff0000, 32'h80010000, 32'sh00040000, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 1'b1);

      // Kochanek-Bartels with the closed flag set, which this mode ignores, and a step
      // below the floor, which the block raises to the floor.
      configure(1'b1, 1'b1, 16'd0);
      send_point(0, 0, 0, 32'sh00010000, 32'sh00010000, 32'sh00010000, 1'b0);
      send_point(32'sh00010000, 32'sh00020000, 32'sh00030000, 0, 0, 0, 1'b0);
      send_point(32'sh00040000, -32'sh00020000, 32'sh00010000, 0, 0, 0, 1'b0);
      send_point(32'sh00080000, 32'sh00010000, -32'sh00030000, 0, 0, 0, 1'b0);
      send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 32'h80000000, 1'b1);
      configure(1'b1, 1'b0, 16'hffff);
      for (int i = 0; i < 4; i++)
         send_point(i[0] ? 32'h80000000 : 32'h7fffffff, 32'sh00010000 * i, 0,
                    i[1] ? 32'h7fffffff : 32'h80000000, -32'sh00008000, 32'sh00008000,
                    i == 3);

      // Random part, one phase per setting. Each reconfiguration first drains all
      // expected samples, which also holds the sender off until the block is empty.
      // Every phase ends its last curve, so modes never change inside a curve.
      configure(1'b0, 1'b0, 16'd3277);
      random_curves(40, 1'b0);
      configure(1'b1, 1'b0, 16'd8192);
      random_curves(40, 1'b1);
      configure(1'b0, 1'b1, 16'hffff);
      random_curves(40, 1'b0);
      configure(1'b1, 1'b1, 16'd1000);
      random_curves(40, 1'b1);
      configure(1'b0, 1'b1, 16'd4096);
      random_curves(40, 1'b0);
      configure(1'b0, 1'b0, 16'd20000);
      no_idle = 1'b1;
      random_curves(40, 1'b0);

      drain();
      $display("Sent %0d control points in both spline modes, open and closed, six steps;",
               point_count);
      $display("checked %0d curve samples.", sample_count);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
